/* src/ulaw_packet_framer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mu-law packet framer
// Shared helpers for the concurrent checks at the end of the front, queue and back modules.
// ----------------------------------------------------------------------------
`ifndef ULAW_PACKET_FRAMER_ASSERT_SVH
`define ULAW_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ULPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ulpf check failed");

// Next-cycle implication, checked outside reset.
`define ULPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ulpf check failed");

`endif

/* src/ulpf_pkg.sv */
// ----------------------------------------------------------------------------
// ulpf_pkg
// Types and constants shared by the mu-law packet framer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ulpf_pkg;

    localparam int POS_W = 8;
    localparam int SEQ_W = 16;
    localparam int IDX_W = 3;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_START  = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    // Header byte slots, then the payload byte
    localparam logic [IDX_W-1:0] IDX_SEQ_LO  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SEQ_HI  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_CNT_LO  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_CNT_HI  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_LEN_LO  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_LEN_HI  = 3'd5;
    localparam logic [IDX_W-1:0] IDX_PAYLOAD = 3'd6;

    localparam logic [15:0] ULAW_BIAS = 16'h0084;
    localparam logic [15:0] ULAW_CLIP = 16'd32635;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [15:0] sample;
        logic              delivered_ok;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_packet;
    } t_out;

    // One encoded sample waiting for serialization
    typedef struct packed {
        logic             hdr;
        logic [SEQ_W-1:0] seq;
        logic [7:0]       code;
        logic             last;
    } t_job;

endpackage

/* src/ulpf_front.sv */
// ----------------------------------------------------------------------------
// ulpf_front
// Accepts items, keeps sequence and frame state, encodes samples to mu-law.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ulaw_packet_framer_assert.svh"

module ulpf_front
    import ulpf_pkg::*;
#(
    parameter int FRAME_LEN = 160
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data,
    input  logic i_full,
    output logic o_push,
    output t_job o_job
);

    localparam logic [POS_W:0] LenX = (POS_W+1)'(FRAME_LEN);

    logic             r_enable;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             accept;
    logic [POS_W:0]   pos_inc;
    logic             is_last;
    logic [7:0]       code;

    // mu-law encode: split sign, clip, bias, find leading one, take mantissa
    logic        sgn;
    logic [15:0] mag_raw;
    logic [15:0] mag_clip;
    logic [14:0] mag_b;
    logic [2:0]  expo;
    logic [3:0]  shamt;
    logic [3:0]  mant;

    always_comb begin
        sgn      = i_in.sample[15];
        mag_raw  = sgn ? 16'(-i_in.sample) : 16'(i_in.sample);
        mag_clip = (mag_raw > ULAW_CLIP) ? ULAW_CLIP : mag_raw;
        mag_b    = 15'(mag_clip + ULAW_BIAS);
        expo     = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mag_b[7+i]) begin
                expo = 3'(i);
            end
        end
        shamt = 4'(expo) + 4'd3;
        mant  = 4'(mag_b >> shamt);
        code  = ~{sgn, expo, mant};
    end

    assign o_in_ready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign pos_inc     = {1'b0, r_pos} + (POS_W+1)'(1);
    assign is_last     = (pos_inc >= LenX);

    always_comb begin
        n_seq  = r_seq;
        n_pos  = r_pos;
        o_push = 1'b0;
        if (accept) begin
            unique case (i_in.kind)
                KIND_SAMPLE: begin
                    if (r_enable) begin
                        o_push = 1'b1;
                        n_pos  = is_last ? '0 : pos_inc[POS_W-1:0];
                    end
                end
                KIND_REPORT: begin
                    if (i_in.delivered_ok) begin
                        n_seq = r_seq + SEQ_W'(1);
                    end
                end
                KIND_START: begin
                    n_seq = '0;
                    n_pos = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_job.hdr  = (r_pos == '0);
        o_job.seq  = r_seq;
        o_job.code = code;
        o_job.last = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_seq    <= '0;
            r_pos    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_enable <= i_cfg_data;
            end
            r_seq <= n_seq;
            r_pos <= n_pos;
        end
    end

    `ULPF_ASSERT_NOW(a_pos_in_frame, i_clk, i_rst_n, 1'b1, ({1'b0, r_pos} < LenX))
    `ULPF_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, o_push, !i_full)

endmodule

/* src/ulpf_fifo.sv */
// ----------------------------------------------------------------------------
// ulpf_fifo
// Short register queue of encoded jobs between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ulaw_packet_framer_assert.svh"

module ulpf_fifo
    import ulpf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FullCnt);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + PtrW'(1);
            end
            r_count <= n_count;
        end
    end

    `ULPF_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, i_pop, (r_count != '0))
    `ULPF_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, (r_count <= FullCnt))

endmodule

/* src/ulpf_back.sv */
// ----------------------------------------------------------------------------
// ulpf_back
// Serializes jobs to header and payload bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ulaw_packet_framer_assert.svh"

module ulpf_back
    import ulpf_pkg::*;
#(
    parameter int FRAME_LEN = 160
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_head,
    input  logic i_empty,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam logic [15:0] LenW = 16'(FRAME_LEN);

    logic             r_valid;
    t_out             r_out;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] sel;
    logic             load;
    logic             emit;
    t_out             n_out;

    assign load = !r_valid || i_out_ready;
    assign emit = load && !i_empty;
    assign sel  = i_head.hdr ? r_idx : IDX_PAYLOAD;

    always_comb begin
        n_out.last_of_packet = 1'b0;
        unique case (sel) inside
            IDX_SEQ_LO: n_out.out_byte = i_head.seq[7:0];
            IDX_SEQ_HI: n_out.out_byte = i_head.seq[15:8];
            IDX_CNT_LO, IDX_LEN_LO: n_out.out_byte = LenW[7:0];
            IDX_CNT_HI, IDX_LEN_HI: n_out.out_byte = LenW[15:8];
            default: begin
                n_out.out_byte       = i_head.code;
                n_out.last_of_packet = i_head.last;
            end
        endcase
    end

    assign o_pop = emit && (sel == IDX_PAYLOAD);

    always_comb begin
        n_idx = r_idx;
        if (o_pop) begin
            n_idx = '0;
        end else if (emit) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            r_idx <= n_idx;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    // Mid-header, the job being framed must still sit at the queue head
    `ULPF_ASSERT_NOW(a_idx_on_header, i_clk, i_rst_n, (r_idx != '0), (!i_empty && i_head.hdr))

endmodule

/* src/ulaw_packet_framer.sv */
// ----------------------------------------------------------------------------
// ulaw_packet_framer
// mu-law encoder that frames samples into packets with a six-byte header.
// ----------------------------------------------------------------------------
// Channel   Signals                              Direction
// input     i_in_valid / o_in_ready / i_in       in : kind, sample, delivered_ok
// output    o_out_valid / i_out_ready / o_out    out: out_byte, last_of_packet
// config    i_cfg_valid / o_cfg_ready / i_cfg_data  in : stream_enable
//
// An item is accepted whenever the job queue has room; a sample is written
// into the queue while the stream is enabled, then taken from its head into the output register.
// The serializer sends one byte per cycle while the output is not stalled: six header bytes and
// the payload byte for a sample that opens a packet, the payload byte alone for any other sample.
// Output stalls fill the FIFO_DEPTH-entry queue before input ready drops.
// Reset is synchronous, active low, and clears state, queue and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulaw_packet_framer
    import ulpf_pkg::*;
#(
    parameter int FRAME_LEN  = 160,
    parameter int FIFO_DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    logic push, pop, empty, full;
    t_job job_in, job_head;

    ulpf_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job_in)
    );

    ulpf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_empty (empty),
        .o_full  (full)
    );

    ulpf_back #(
        .FRAME_LEN (FRAME_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (job_head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* sim/ulaw_packet_framer_test.sv */
// ----------------------------------------------------------------------------
// ulaw_packet_framer_test
// Self-checking bench for the mu-law packet framer. A clocked driver feeds
// input transfers from a queue and predicts the header and payload bytes of
// each one. A clocked monitor compares every output transfer, field by field,
// with the oldest predicted byte. Phases vary idling on both sides and the
// stream enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulaw_packet_framer_test;
    import ulpf_pkg::*;

    localparam int FRAME_LEN    = 160;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;

    // Predictor state
    logic             stream_on;
    logic [SEQ_W-1:0] seq_num;
    logic [POS_W-1:0] frame_pos;

    t_in  pending_items[$];
    t_out expected_bytes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int quiet_cycles;

    ulaw_packet_framer #(
        .FRAME_LEN(FRAME_LEN)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] ulaw_code(logic signed [15:0] pcm);
        int         mag;
        logic [2:0] expo;
        logic [3:0] mant;
        logic [7:0] sign;
        sign = pcm[15] ? 8'h80 : 8'h00;
        mag  = pcm;
        if (mag < 0) mag = -mag;
        if (mag > int'(ULAW_CLIP)) mag = int'(ULAW_CLIP);
        mag += int'(ULAW_BIAS);
        // leading one between bit 14 and bit 8 sets the segment
        expo = 3'd0;
        for (int b = 1; b <= 7; b++) begin
            if (mag[b + 7]) expo = 3'(b);
        end
        mant = 4'((mag >> (expo + 3)) & 'h0f);
        return ~(sign | {1'b0, expo, 4'h0} | {4'h0, mant});
    endfunction

    function automatic void push_byte(logic [7:0] b, logic last);
        t_out r;
        r.out_byte       = b;
        r.last_of_packet = last;
        expected_bytes.push_back(r);
    endfunction

    function automatic void predict_frame_bytes(t_in item);
        logic [15:0] len;
        len = 16'(FRAME_LEN);
        case (t_kind'(item.kind))
            KIND_REPORT: begin
                if (item.delivered_ok) seq_num = seq_num + 1'b1;
            end
            KIND_START: begin
                seq_num   = '0;
                frame_pos = '0;
            end
            KIND_SAMPLE: begin
                if (stream_on) begin
                    if (frame_pos == 0) begin
                        push_byte(seq_num[7:0], 1'b0);
                        push_byte(seq_num[15:8], 1'b0);
                        push_byte(len[7:0], 1'b0);
                        push_byte(len[15:8], 1'b0);
                        push_byte(len[7:0], 1'b0);
                        push_byte(len[15:8], 1'b0);
                    end
                    if (int'(frame_pos) + 1 >= FRAME_LEN) begin
                        push_byte(ulaw_code(item.sample), 1'b1);
                        frame_pos = '0;
                    end else begin
                        push_byte(ulaw_code(item.sample), 1'b0);
                        frame_pos = frame_pos + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_in make_item(t_kind k, int pcm, bit ok);
        t_in item;
        item.kind         = k;
        item.sample       = 16'(pcm);
        item.delivered_ok = ok;
        return item;
    endfunction

    // Mostly samples so packets run to their end; starts stay rare
    function automatic t_in random_item();
        int    pick;
        int    pcm;
        t_kind k;
        pick = $urandom_range(99);
        if (pick < 86)      k = KIND_SAMPLE;
        else if (pick < 93) k = KIND_REPORT;
        else if (pick < 95) k = KIND_START;
        else                k = KIND_UNUSED;
        if ($urandom_range(3) == 0) pcm = int'($urandom_range(600)) - 300;
        else                        pcm = int'($urandom_range(16'hffff));
        return make_item(k, pcm, 1'($urandom_range(1)));
    endfunction

    function automatic t_in random_item_sample();
        return make_item(KIND_SAMPLE, int'($urandom_range(16'hffff)),
                         1'($urandom_range(1)));
    endfunction

    // Input driver: present the next queued item, hold it until the transfer
    always @(posedge i_clk) begin : sample_driver
        t_in nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_frame_bytes(i_in);
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    i_in       <= nxt;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each transfer against the oldest predicted byte
    always @(posedge i_clk) begin : byte_monitor
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output: out_byte %02h last_of_packet %0b",
                       o_out.out_byte, o_out.last_of_packet);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, actual %02h",
                           want.out_byte, o_out.out_byte);
                    error_count++;
                end
                if (o_out.last_of_packet !== want.last_of_packet) begin
                    $error("last_of_packet: expected %0b, actual %0b",
                           want.last_of_packet, o_out.last_of_packet);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stream_enable(logic en);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        stream_on = en;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int count, int send_pct, int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        repeat (count) pending_items.push_back(random_item());
        wait_idle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 1'b0;
        stream_on      = 1'b0;
        seq_num        = '0;
        frame_pos      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        quiet_cycles   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stream still disabled: samples dropped, reports still act, unused kind ignored
        pending_items.push_back(make_item(KIND_SAMPLE, 1234, 1'b0));
        pending_items.push_back(make_item(KIND_REPORT, 0, 1'b1));
        pending_items.push_back(make_item(KIND_REPORT, 0, 1'b0));
        pending_items.push_back(make_item(KIND_UNUSED, -7, 1'b1));
        pending_items.push_back(make_item(KIND_SAMPLE, -32768, 1'b1));
        wait_idle();
        write_stream_enable(1'b1);

        // Encoder extremes and segment edges, then reports and a start mid-packet
        pending_items.push_back(make_item(KIND_SAMPLE, 0, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, 32767, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, -32768, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, -1, 1'b1));
        pending_items.push_back(make_item(KIND_SAMPLE, 1, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, 32635, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, 32636, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, -32635, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, 127, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, 128, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, -4000, 1'b0));
        pending_items.push_back(make_item(KIND_UNUSED, 555, 1'b1));
        pending_items.push_back(make_item(KIND_REPORT, 0, 1'b1));
        pending_items.push_back(make_item(KIND_START, 0, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, 'h7f00, 1'b0));
        pending_items.push_back(make_item(KIND_REPORT, 0, 1'b0));
        pending_items.push_back(make_item(KIND_SAMPLE, 'h1234, 1'b1));
        wait_idle();

        run_phase(60, 0, 0);
        run_phase(60, 74, 0);
        write_stream_enable(1'b0);
        run_phase(30, 0, 0);
        write_stream_enable(1'b1);
        run_phase(60, 0, 74);
        // Sender holds off between the halves until every byte is out
        run_phase(40, 29, 29);
        run_phase(40, 29, 29);

        // Open a fresh packet, run it to its last byte, then start the next
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pending_items.push_back(make_item(KIND_START, 0, 1'b0));
        repeat (FRAME_LEN) pending_items.push_back(random_item_sample());
        pending_items.push_back(make_item(KIND_REPORT, 0, 1'b1));
        pending_items.push_back(make_item(KIND_SAMPLE, -300, 1'b0));
        wait_idle();

        run_phase(40, 74, 74);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* ulaw_packet_framer.f */
+incdir+src
src/ulpf_pkg.sv
src/ulpf_front.sv
src/ulpf_fifo.sv
src/ulpf_back.sv
src/ulaw_packet_framer.sv
sim/ulaw_packet_framer_test.sv
